>>> design/tdac_pkg.sv
// types and codes shared by the trust domain access checker modules
`timescale 1ns / 1ps
package tdac_pkg;

    localparam logic [2:0] REQ_SET    = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_CHECK  = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_DENIED  = 2'd3;

    localparam logic [1:0] CFG_ALLOW   = 2'd0;
    localparam logic [1:0] CFG_DEFAULT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] id_a_hi;
        logic [63:0] id_a_lo;
        logic [63:0] id_b_hi;
        logic [63:0] id_b_lo;
        logic [3:0]  new_domain;
        logic [3:0]  log_index;
        logic [63:0] timestamp;
        logic        scan;
    } t_item;

    typedef struct packed {
        logic [15:0] allow_matrix;
        logic [1:0]  default_domain;
    } t_cfg;

endpackage

>>> design/tdac_front.sv
// front end: accepts items, classifies them and queues them for the engine
`timescale 1ns / 1ps
module tdac_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  logic [2:0]      i_req_type,
    input  logic [63:0]     i_id_a_hi,
    input  logic [63:0]     i_id_a_lo,
    input  logic [63:0]     i_id_b_hi,
    input  logic [63:0]     i_id_b_lo,
    input  logic [3:0]      i_new_domain,
    input  logic [3:0]      i_log_index,
    input  logic [63:0]     i_timestamp,
    input  logic            i_pop,
    output logic            o_head_valid,
    output tdac_pkg::t_item o_head
);

    tdac_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    tdac_pkg::t_item item;

    assign o_busy       = (r_cnt == 2'd2);
    assign push         = i_start && !o_busy;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_comb begin
        item.req_type   = i_req_type;
        item.id_a_hi    = i_id_a_hi;
        item.id_a_lo    = i_id_a_lo;
        item.id_b_hi    = i_id_b_hi;
        item.id_b_lo    = i_id_b_lo;
        item.new_domain = i_new_domain;
        item.log_index  = i_log_index;
        item.timestamp  = i_timestamp;
        // table walk needed for set, lookup and check
        item.scan       = (i_req_type == tdac_pkg::REQ_SET) ||
                          (i_req_type == tdac_pkg::REQ_LOOKUP) ||
                          (i_req_type == tdac_pkg::REQ_CHECK);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

>>> design/tdac_back.sv
// back end: table walk, table and log memories, result registers
`timescale 1ns / 1ps
module tdac_back #(
    parameter int TABLE_ENTRIES = 64,
    parameter int LOG_ENTRIES   = 16,
    parameter int DOMAIN_COUNT  = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tdac_pkg::t_cfg  i_cfg,
    input  logic            i_head_valid,
    input  tdac_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [1:0]      o_domain_a,
    output logic [1:0]      o_domain_b,
    output logic [4:0]      o_violation_count,
    output logic            o_entry_valid,
    output logic [63:0]     o_entry_offender_hi,
    output logic [63:0]     o_entry_offender_lo,
    output logic [63:0]     o_entry_owner_hi,
    output logic [63:0]     o_entry_owner_lo,
    output logic [1:0]      o_entry_offender_domain,
    output logic [1:0]      o_entry_owner_domain,
    output logic [63:0]     o_entry_time
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
    localparam int CW = $clog2(LOG_ENTRIES + 1);

    tdac_pkg::t_state r_state, n_state;
    tdac_pkg::t_item  r_item;

    logic [63:0] tab_hi  [TABLE_ENTRIES];
    logic [63:0] tab_lo  [TABLE_ENTRIES];
    logic [1:0]  tab_dom [TABLE_ENTRIES];
    logic        r_active [TABLE_ENTRIES];

    logic [63:0] log_off_hi [LOG_ENTRIES];
    logic [63:0] log_off_lo [LOG_ENTRIES];
    logic [63:0] log_own_hi [LOG_ENTRIES];
    logic [63:0] log_own_lo [LOG_ENTRIES];
    logic [3:0]  log_dom    [LOG_ENTRIES];
    logic [63:0] log_tim    [LOG_ENTRIES];

    logic [63:0] r_lr_off_hi, r_lr_off_lo, r_lr_own_hi, r_lr_own_lo, r_lr_tim;
    logic [3:0]  r_lr_dom;
    logic [CW-1:0] r_count, n_count;

    logic [IW-1:0] r_addr, r_cmp_idx;
    logic          r_launch, r_cmp_valid, r_cmp_last;
    logic [63:0]   r_rd_hi, r_rd_lo;
    logic [1:0]    r_rd_dom;

    logic          r_hit_a, r_hit_b, r_free;
    logic [IW-1:0] r_hit_a_idx, r_free_idx;
    logic [1:0]    r_dom_a, r_dom_b;

    logic          tab_we, act_we, log_we;
    logic [IW-1:0] tab_wa;
    logic [LW-1:0] log_wa;
    logic [1:0]    ad, od;
    logic [5:0]    bitn;
    logic          allowed, rd_ok, log_full;
    logic [1:0]    n_status, n_da, n_db;

    assign o_pop = (r_state == tdac_pkg::S_IDLE) && i_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdac_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdac_pkg::S_IDLE: begin
                if (i_head_valid) begin
                    n_state = i_head.scan ? tdac_pkg::S_SCAN : tdac_pkg::S_EXEC;
                end
            end
            tdac_pkg::S_SCAN: begin
                if (r_cmp_valid && r_cmp_last) begin
                    n_state = tdac_pkg::S_EXEC;
                end
            end
            tdac_pkg::S_EXEC: begin
                n_state = tdac_pkg::S_IDLE;
            end
            default: n_state = tdac_pkg::S_IDLE;
        endcase
    end

    // table walk pipeline: address, registered read, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch    <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_launch <= i_head.scan;
            end else if (r_launch && r_addr == IW'(TABLE_ENTRIES - 1)) begin
                r_launch <= 1'b0;
            end
            r_cmp_valid <= r_launch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
            r_addr <= '0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            if (r_launch) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_cmp_valid) begin
                if (r_active[r_cmp_idx] && !r_hit_a && r_rd_hi == r_item.id_a_hi &&
                    r_rd_lo == r_item.id_a_lo) begin
                    r_hit_a     <= 1'b1;
                    r_hit_a_idx <= r_cmp_idx;
                    r_dom_a     <= r_rd_dom;
                end
                if (r_active[r_cmp_idx] && !r_hit_b && r_rd_hi == r_item.id_b_hi &&
                    r_rd_lo == r_item.id_b_lo) begin
                    r_hit_b <= 1'b1;
                    r_dom_b <= r_rd_dom;
                end
                if (!r_active[r_cmp_idx] && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
        r_cmp_idx  <= r_addr;
        r_cmp_last <= (r_addr == IW'(TABLE_ENTRIES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (r_launch) begin
            r_rd_hi  <= tab_hi[r_addr];
            r_rd_lo  <= tab_lo[r_addr];
            r_rd_dom <= tab_dom[r_addr];
        end
        if (tab_we) begin
            tab_hi[tab_wa]  <= r_item.id_a_hi;
            tab_lo[tab_wa]  <= r_item.id_a_lo;
            tab_dom[tab_wa] <= r_item.new_domain[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_active[i] <= 1'b0;
            end
        end else if (act_we) begin
            r_active[tab_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_lr_off_hi <= log_off_hi[LW'(i_head.log_index)];
            r_lr_off_lo <= log_off_lo[LW'(i_head.log_index)];
            r_lr_own_hi <= log_own_hi[LW'(i_head.log_index)];
            r_lr_own_lo <= log_own_lo[LW'(i_head.log_index)];
            r_lr_dom    <= log_dom[LW'(i_head.log_index)];
            r_lr_tim    <= log_tim[LW'(i_head.log_index)];
        end
        if (log_we) begin
            log_off_hi[log_wa] <= r_item.id_a_hi;
            log_off_lo[log_wa] <= r_item.id_a_lo;
            log_own_hi[log_wa] <= r_item.id_b_hi;
            log_own_lo[log_wa] <= r_item.id_b_lo;
            log_dom[log_wa]    <= {od, ad};
            log_tim[log_wa]    <= r_item.timestamp;
        end
    end

    always_comb begin
        ad       = r_hit_a ? r_dom_a : i_cfg.default_domain;
        od       = r_hit_b ? r_dom_b : i_cfg.default_domain;
        bitn     = 6'(ad) * 6'(DOMAIN_COUNT) + 6'(od);
        allowed  = (bitn < 6'd16) && i_cfg.allow_matrix[bitn[3:0]];
        log_full = (r_count >= CW'(LOG_ENTRIES));
        log_wa   = log_full ? LW'(LOG_ENTRIES - 1) : LW'(r_count);
        rd_ok    = (9'(r_item.log_index) < 9'(r_count)) &&
                   (9'(r_item.log_index) < 9'(LOG_ENTRIES));
        tab_we   = 1'b0;
        act_we   = 1'b0;
        log_we   = 1'b0;
        tab_wa   = r_hit_a_idx;
        n_status = tdac_pkg::ST_OK;
        n_da     = 2'd0;
        n_db     = 2'd0;
        n_count  = r_count;
        if (r_state == tdac_pkg::S_EXEC) begin
            unique case (r_item.req_type)
                tdac_pkg::REQ_SET: begin
                    if (r_item.new_domain >= 4'(DOMAIN_COUNT)) begin
                        n_status = tdac_pkg::ST_INVALID;
                    end else if (r_hit_a) begin
                        tab_we = 1'b1;
                    end else if (r_free) begin
                        tab_we = 1'b1;
                        act_we = 1'b1;
                        tab_wa = r_free_idx;
                    end else begin
                        n_status = tdac_pkg::ST_FULL;
                    end
                end
                tdac_pkg::REQ_LOOKUP: begin
                    n_da = ad;
                end
                tdac_pkg::REQ_CHECK: begin
                    n_da = ad;
                    n_db = od;
                    if (4'(ad) >= 4'(DOMAIN_COUNT) || 4'(od) >= 4'(DOMAIN_COUNT)) begin
                        n_status = tdac_pkg::ST_INVALID;
                    end else if (!allowed) begin
                        n_status = tdac_pkg::ST_DENIED;
                        log_we   = 1'b1;
                        if (!log_full) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                tdac_pkg::REQ_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            o_valid <= (r_state == tdac_pkg::S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tdac_pkg::S_EXEC) begin
            logic rd;
            rd = (r_item.req_type == tdac_pkg::REQ_READ) && rd_ok;
            o_status                <= n_status;
            o_domain_a              <= n_da;
            o_domain_b              <= n_db;
            o_violation_count       <= 5'(n_count);
            o_entry_valid           <= rd;
            o_entry_offender_hi     <= rd ? r_lr_off_hi : 64'd0;
            o_entry_offender_lo     <= rd ? r_lr_off_lo : 64'd0;
            o_entry_owner_hi        <= rd ? r_lr_own_hi : 64'd0;
            o_entry_owner_lo        <= rd ? r_lr_own_lo : 64'd0;
            o_entry_offender_domain <= rd ? r_lr_dom[1:0] : 2'd0;
            o_entry_owner_domain    <= rd ? r_lr_dom[3:2] : 2'd0;
            o_entry_time            <= rd ? r_lr_tim : 64'd0;
        end
    end

endmodule

>>> design/trust_domain_access_checker_core.sv
// top level of the trust domain access checker: config registers, front and back
//
// channel   direction  handshake
// request   in         i_start, accepted when i_start and !o_busy
// result    out        o_valid, one cycle strobe, always taken
// config    in         i_cfg_valid / o_cfg_ready, index and data
//
// set, lookup and check walk the whole table in the scan state before the execute state gives
// their result; read, clear and unknown requests go from idle straight to the execute state
// the engine works on one item at a time: it takes the next from the queue only back in idle
// a two item queue sits in front of the engine; o_busy rises when it is full
// synchronous active low reset clears queue, engine, log count and table valid bits
`timescale 1ns / 1ps
module trust_domain_access_checker_core #(
    parameter int TABLE_ENTRIES = 64,
    parameter int LOG_ENTRIES   = 16,
    parameter int DOMAIN_COUNT  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_id_a_hi,
    input  logic [63:0] i_id_a_lo,
    input  logic [63:0] i_id_b_hi,
    input  logic [63:0] i_id_b_lo,
    input  logic [3:0]  i_new_domain,
    input  logic [3:0]  i_log_index,
    input  logic [63:0] i_timestamp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [1:0]  o_domain_a,
    output logic [1:0]  o_domain_b,
    output logic [4:0]  o_violation_count,
    output logic        o_entry_valid,
    output logic [63:0] o_entry_offender_hi,
    output logic [63:0] o_entry_offender_lo,
    output logic [63:0] o_entry_owner_hi,
    output logic [63:0] o_entry_owner_lo,
    output logic [1:0]  o_entry_offender_domain,
    output logic [1:0]  o_entry_owner_domain,
    output logic [63:0] o_entry_time
);

    tdac_pkg::t_cfg  r_cfg;
    tdac_pkg::t_item head;
    logic            head_valid, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tdac_pkg::CFG_ALLOW) begin
                r_cfg.allow_matrix <= i_cfg_data;
            end else if (i_cfg_index == tdac_pkg::CFG_DEFAULT) begin
                r_cfg.default_domain <= i_cfg_data[1:0];
            end
        end
    end

    tdac_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_req_type   (i_req_type),
        .i_id_a_hi    (i_id_a_hi),
        .i_id_a_lo    (i_id_a_lo),
        .i_id_b_hi    (i_id_b_hi),
        .i_id_b_lo    (i_id_b_lo),
        .i_new_domain (i_new_domain),
        .i_log_index  (i_log_index),
        .i_timestamp  (i_timestamp),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    tdac_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .LOG_ENTRIES   (LOG_ENTRIES),
        .DOMAIN_COUNT  (DOMAIN_COUNT)
    ) u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg                   (r_cfg),
        .i_head_valid            (head_valid),
        .i_head                  (head),
        .o_pop                   (pop),
        .o_valid                 (o_valid),
        .o_status                (o_status),
        .o_domain_a              (o_domain_a),
        .o_domain_b              (o_domain_b),
        .o_violation_count       (o_violation_count),
        .o_entry_valid           (o_entry_valid),
        .o_entry_offender_hi     (o_entry_offender_hi),
        .o_entry_offender_lo     (o_entry_offender_lo),
        .o_entry_owner_hi        (o_entry_owner_hi),
        .o_entry_owner_lo        (o_entry_owner_lo),
        .o_entry_offender_domain (o_entry_offender_domain),
        .o_entry_owner_domain    (o_entry_owner_domain),
        .o_entry_time            (o_entry_time)
    );

endmodule
